@@ rtl/gc1d_pkg.sv @@
// Shared types, constants and codes for the grouped 1-D convolution point engine.
package gc1d_pkg;

   localparam int MAX_CHANNELS = 1024;
   localparam int MAX_FRAMES   = 256;
   localparam int MAX_TAPS     = 128;
   localparam int WEIGHT_WORDS = 1048576;

   localparam int WADDR_W = $clog2(WEIGHT_WORDS);
   localparam int CHAN_W  = $clog2(MAX_CHANNELS);
   localparam int FRAME_W = $clog2(MAX_FRAMES);
   localparam int SADDR_W = FRAME_W + CHAN_W;
   localparam int DIV_W   = 11;
   localparam int ACC_W   = 50;

   typedef enum logic [1:0] {
      FUNC_WEIGHT  = 2'd0,
      FUNC_BIAS    = 2'd1,
      FUNC_SAMPLE  = 2'd2,
      FUNC_COMPUTE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_RANGE  = 2'd1,
      STAT_CONFIG = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_IN_CHANNELS  = 3'd0,
      REG_OUT_CHANNELS = 3'd1,
      REG_KERNEL_TAPS  = 3'd2,
      REG_PAD_FRAMES   = 3'd3,
      REG_STRIDE       = 3'd4,
      REG_GROUP_COUNT  = 3'd5,
      REG_BIAS_ENABLE  = 3'd6,
      REG_INPUT_FRAMES = 3'd7
   } reg_idx_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_DIV_IN, ST_DIV_OUT, ST_MUL_KC, ST_MUL_TOT, ST_TOT_CHK,
      ST_DIV_TOUT, ST_DIV_GRP, ST_MUL_WB, ST_MUL_GB, ST_MUL_JS, ST_SETUP, ST_TAP,
      ST_CHAN, ST_DRAIN, ST_BIAS, ST_OUT
   } state_type;

   typedef struct packed {
      logic                      weight_we;
      logic                      bias_we;
      logic                      sample_we;
      logic [WADDR_W-1:0]        weight_addr;
      logic [CHAN_W-1:0]         chan;
      logic [FRAME_W-1:0]        frame;
      logic signed [15:0]        small_value;
      logic signed [31:0]        bias_value;
   } wr_type;

endpackage

@@ rtl/grouped_conv1d_point.sv @@
// Top level: stream and register ports, setup sequencer and MAC loop control.
//
//  channel  | group              | width        | role
//  req      | tvalid/tready      | 88 + 2 user  | write or compute transaction in
//  rsp      | tvalid/tready      | 32 + 2 user  | result and status out
//  csr      | APB psel..prdata   | 5 addr, 32   | layer registers
//
// Write transactions are answered from idle. A compute first runs setup (four
// divides on the shared divider, five passes on the shared multiplier), then steps
// through the taps and issues cin_g multiply-accumulates for each tap inside the input
// frames on the single multiply-accumulate unit, then last tap check, drain, bias and
// output.
// Reset clears the sequencer and the result valid flag and loads the layer defaults;
// the stores are not cleared. A stalled result blocks new transactions until taken.
module grouped_conv1d_point (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] frame_index, [17:8] channel_index, [37:18] weight_address,
   // [53:38] small_value, [85:54] bias_value, [87:86] zero
   input  logic [87:0]  req_tdata,
   // [1:0] func
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] conv_result
   output logic [31:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import gc1d_pkg::*;

   // layer registers
   logic [10:0] in_ch_ff, out_ch_ff, group_ff;
   logic [7:0]  taps_ff;
   logic [6:0]  pad_ff;
   logic [4:0]  stride_ff;
   logic        bias_en_ff;
   logic [8:0]  tin_ff;
   logic        csr_wr;
   reg_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff   <= 11'd512;
         out_ch_ff  <= 11'd512;
         taps_ff    <= 8'd3;
         pad_ff     <= 7'd0;
         stride_ff  <= 5'd2;
         group_ff   <= 11'd1;
         bias_en_ff <= 1'b0;
         tin_ff     <= 9'd256;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_IN_CHANNELS:  in_ch_ff   <= csr_pwdata[10:0];
            REG_OUT_CHANNELS: out_ch_ff  <= csr_pwdata[10:0];
            REG_KERNEL_TAPS:  taps_ff    <= csr_pwdata[7:0];
            REG_PAD_FRAMES:   pad_ff     <= csr_pwdata[6:0];
            REG_STRIDE:       stride_ff  <= csr_pwdata[4:0];
            REG_GROUP_COUNT:  group_ff   <= csr_pwdata[10:0];
            REG_BIAS_ENABLE:  bias_en_ff <= csr_pwdata[0];
            REG_INPUT_FRAMES: tin_ff     <= csr_pwdata[8:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_IN_CHANNELS:  csr_prdata = {21'd0, in_ch_ff};
         REG_OUT_CHANNELS: csr_prdata = {21'd0, out_ch_ff};
         REG_KERNEL_TAPS:  csr_prdata = {24'd0, taps_ff};
         REG_PAD_FRAMES:   csr_prdata = {25'd0, pad_ff};
         REG_STRIDE:       csr_prdata = {27'd0, stride_ff};
         REG_GROUP_COUNT:  csr_prdata = {21'd0, group_ff};
         REG_BIAS_ENABLE:  csr_prdata = {31'd0, bias_en_ff};
         REG_INPUT_FRAMES: csr_prdata = {23'd0, tin_ff};
      endcase
   end

   // request fields
   logic [FRAME_W-1:0] f_frame;
   logic [CHAN_W-1:0]  f_chan;
   func_type           f_func;
   logic               req_acc;
   assign f_frame = req_tdata[7:0];
   assign f_chan  = req_tdata[17:8];
   assign f_func  = func_type'(req_tuser);
   assign req_acc = req_tvalid && req_tready;

   // sequencer state
   state_type state_ff, state_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;
   status_type         stat_ff, stat_in;
   logic [10:0]        cin_ff, cin_in, cout_ff, cout_in;
   logic [18:0]        kc_ff, kc_in;
   logic [10:0]        grp_ff, grp_in;
   logic [WADDR_W-1:0] wbase_ff, wbase_in, waddr_ff, waddr_in;
   logic [CHAN_W-1:0]  gbase_ff, gbase_in;
   logic signed [14:0] pos_ff, pos_in;
   logic [7:0]         tap_ff, tap_in;
   logic [10:0]        c_ff, c_in;
   logic [1:0]         drn_ff, drn_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   status_type         rsp_stat_ff, rsp_stat_in;
   logic               rdv_ff;

   // shared multiplier and divider
   logic [10:0] mul_a;
   logic [18:0] mul_b;
   logic [29:0] mul_ff;
   logic        div_start, div_done;
   logic [DIV_W-1:0] div_num, div_den, div_quo, div_rem;

   // datapath hooks
   logic        issue, mac_clear, bias_add;
   logic        cfg_bad, pos_ok, slot_free;
   logic [10:0] span;
   logic [9:0]  tout;
   logic signed [31:0] sat_result, bias_rdata;
   logic signed [15:0] weight_rdata, sample_rdata;
   wr_type      wr;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign span       = {2'd0, tin_ff} + {3'd0, pad_ff, 1'b0};
   assign tout       = div_quo[9:0] + 10'd1;
   assign pos_ok     = !pos_ff[14] && (pos_ff[13:0] < {5'd0, tin_ff});

   assign cfg_bad = (in_ch_ff == '0) || (in_ch_ff > 11'(MAX_CHANNELS)) ||
                    (out_ch_ff == '0) || (out_ch_ff > 11'(MAX_CHANNELS)) ||
                    (group_ff == '0) || (group_ff > 11'(MAX_CHANNELS)) ||
                    (taps_ff == '0) || (taps_ff > 8'(MAX_TAPS)) ||
                    (stride_ff == '0) || (tin_ff == '0) ||
                    (tin_ff > 9'(MAX_FRAMES)) || (span < {3'd0, taps_ff});

   always_comb begin
      wr.weight_we   = req_acc && (f_func == FUNC_WEIGHT);
      wr.bias_we     = req_acc && (f_func == FUNC_BIAS);
      wr.sample_we   = req_acc && (f_func == FUNC_SAMPLE);
      wr.weight_addr = req_tdata[37:18];
      wr.chan        = f_chan;
      wr.frame       = f_frame;
      wr.small_value = req_tdata[53:38];
      wr.bias_value  = req_tdata[85:54];
   end

   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      chan_in      = chan_ff;
      stat_in      = stat_ff;
      cin_in       = cin_ff;
      cout_in      = cout_ff;
      kc_in        = kc_ff;
      grp_in       = grp_ff;
      wbase_in     = wbase_ff;
      waddr_in     = waddr_ff;
      gbase_in     = gbase_ff;
      pos_in       = pos_ff;
      tap_in       = tap_ff;
      c_in         = c_ff;
      drn_in       = drn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      issue        = 1'b0;
      mac_clear    = 1'b0;
      bias_add     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (f_func == FUNC_COMPUTE) begin
                  frame_in = f_frame;
                  chan_in  = f_chan;
                  state_in = ST_CHECK;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_stat_in  = STAT_OK;
               end
            end
         end
         ST_CHECK: begin
            if (cfg_bad) begin
               stat_in  = STAT_CONFIG;
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = in_ch_ff;
               div_den   = group_ff;
               state_in  = ST_DIV_IN;
            end
         end
         ST_DIV_IN: begin
            if (div_done) begin
               if (div_rem != '0) begin
                  stat_in  = STAT_CONFIG;
                  state_in = ST_OUT;
               end else begin
                  cin_in    = div_quo;
                  div_start = 1'b1;
                  div_num   = out_ch_ff;
                  div_den   = group_ff;
                  state_in  = ST_DIV_OUT;
               end
            end
         end
         ST_DIV_OUT: begin
            if (div_done) begin
               if (div_rem != '0) begin
                  stat_in  = STAT_CONFIG;
                  state_in = ST_OUT;
               end else begin
                  cout_in  = div_quo;
                  state_in = ST_MUL_KC;
               end
            end
         end
         ST_MUL_KC: begin
            mul_a    = {3'd0, taps_ff};
            mul_b    = {8'd0, cin_ff};
            state_in = ST_MUL_TOT;
         end
         ST_MUL_TOT: begin
            kc_in    = mul_ff[18:0];
            mul_a    = out_ch_ff;
            mul_b    = mul_ff[18:0];
            state_in = ST_TOT_CHK;
         end
         ST_TOT_CHK: begin
            if (mul_ff > 30'(WEIGHT_WORDS)) begin
               stat_in  = STAT_CONFIG;
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = span - {3'd0, taps_ff};
               div_den   = {6'd0, stride_ff};
               state_in  = ST_DIV_TOUT;
            end
         end
         ST_DIV_TOUT: begin
            if (div_done) begin
               if (({2'd0, frame_ff} >= tout) || ({1'b0, chan_ff} >= out_ch_ff)) begin
                  stat_in  = STAT_RANGE;
                  state_in = ST_OUT;
               end else begin
                  div_start = 1'b1;
                  div_num   = {1'b0, chan_ff};
                  div_den   = cout_ff;
                  state_in  = ST_DIV_GRP;
               end
            end
         end
         ST_DIV_GRP: begin
            if (div_done) begin
               grp_in   = div_quo;
               state_in = ST_MUL_WB;
            end
         end
         ST_MUL_WB: begin
            mul_a    = {1'b0, chan_ff};
            mul_b    = kc_ff;
            state_in = ST_MUL_GB;
         end
         ST_MUL_GB: begin
            wbase_in = mul_ff[WADDR_W-1:0];
            mul_a    = grp_ff;
            mul_b    = {8'd0, cin_ff};
            state_in = ST_MUL_JS;
         end
         ST_MUL_JS: begin
            gbase_in = mul_ff[CHAN_W-1:0];
            mul_a    = {3'd0, frame_ff};
            mul_b    = {14'd0, stride_ff};
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            pos_in    = $signed({2'b00, mul_ff[12:0]}) - $signed({8'd0, pad_ff});
            waddr_in  = wbase_ff;
            tap_in    = '0;
            mac_clear = 1'b1;
            state_in  = ST_TAP;
         end
         ST_TAP: begin
            if (tap_ff == taps_ff) begin
               drn_in   = '0;
               state_in = ST_DRAIN;
            end else if (!pos_ok) begin
               // tap falls in padding: skip its weight row
               waddr_in = waddr_ff + WADDR_W'(cin_ff);
               pos_in   = pos_ff + 15'sd1;
               tap_in   = tap_ff + 8'd1;
            end else begin
               c_in     = '0;
               state_in = ST_CHAN;
            end
         end
         ST_CHAN: begin
            issue    = 1'b1;
            waddr_in = waddr_ff + WADDR_W'(1);
            c_in     = c_ff + 11'd1;
            if (c_ff == cin_ff - 11'd1) begin
               pos_in   = pos_ff + 15'sd1;
               tap_in   = tap_ff + 8'd1;
               state_in = ST_TAP;
            end
         end
         ST_DRAIN: begin
            drn_in = drn_ff + 2'd1;
            if (drn_ff == 2'd2) state_in = ST_BIAS;
         end
         ST_BIAS: begin
            bias_add = bias_en_ff;
            stat_in  = STAT_OK;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (stat_ff == STAT_OK) ? sat_result : 32'd0;
               rsp_stat_in  = stat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= issue;
      end
      frame_ff    <= frame_in;
      chan_ff     <= chan_in;
      stat_ff     <= stat_in;
      cin_ff      <= cin_in;
      cout_ff     <= cout_in;
      kc_ff       <= kc_in;
      grp_ff      <= grp_in;
      wbase_ff    <= wbase_in;
      waddr_ff    <= waddr_in;
      gbase_ff    <= gbase_in;
      pos_ff      <= pos_in;
      tap_ff      <= tap_in;
      c_ff        <= c_in;
      drn_ff      <= drn_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
      mul_ff      <= mul_a * mul_b;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

   gc1d_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   gc1d_mem u_mem (
      .clock        (clock),
      .wr           (wr),
      .weight_raddr (waddr_ff),
      .sample_raddr ({pos_ff[FRAME_W-1:0], gbase_ff + c_ff[CHAN_W-1:0]}),
      .bias_raddr   (chan_ff),
      .weight_rdata (weight_rdata),
      .sample_rdata (sample_rdata),
      .bias_rdata   (bias_rdata)
   );

   gc1d_mac u_mac (
      .clock      (clock),
      .clear      (mac_clear),
      .valid      (rdv_ff),
      .sample     (sample_rdata),
      .weight     (weight_rdata),
      .bias_add   (bias_add),
      .bias       (bias_rdata),
      .sat_result (sat_result)
   );
endmodule

@@ rtl/gc1d_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the setup sequencer.
module gc1d_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gc1d_pkg::DIV_W-1:0]    num,
   input  logic [gc1d_pkg::DIV_W-1:0]    den,
   output logic                          done,
   output logic [gc1d_pkg::DIV_W-1:0]    quo,
   output logic [gc1d_pkg::DIV_W-1:0]    rem
);
   import gc1d_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   shifted, trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         rem_in  = trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], ~trial[DIV_W]};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule

@@ rtl/gc1d_mem.sv @@
// Weight, bias and sample stores with registered read ports.
module gc1d_mem (
   input  logic                           clock,
   input  gc1d_pkg::wr_type               wr,
   input  logic [gc1d_pkg::WADDR_W-1:0]   weight_raddr,
   input  logic [gc1d_pkg::SADDR_W-1:0]   sample_raddr,
   input  logic [gc1d_pkg::CHAN_W-1:0]    bias_raddr,
   output logic signed [15:0]             weight_rdata,
   output logic signed [15:0]             sample_rdata,
   output logic signed [31:0]             bias_rdata
);
   import gc1d_pkg::*;

   logic signed [15:0] weight_mem [WEIGHT_WORDS];
   logic signed [15:0] sample_mem [MAX_FRAMES*MAX_CHANNELS];
   logic signed [31:0] bias_mem   [MAX_CHANNELS];

   always_ff @(posedge clock) begin
      if (wr.weight_we) weight_mem[wr.weight_addr] <= wr.small_value;
      weight_rdata <= weight_mem[weight_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr.sample_we) sample_mem[{wr.frame, wr.chan}] <= wr.small_value;
      sample_rdata <= sample_mem[sample_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr.bias_we) bias_mem[wr.chan] <= wr.bias_value;
      bias_rdata <= bias_mem[bias_raddr];
   end
endmodule

@@ rtl/gc1d_mac.sv @@
// Multiply-accumulate unit: registered product, wide accumulator, bias add, saturation.
module gc1d_mac (
   input  logic                clock,
   input  logic                clear,
   input  logic                valid,
   input  logic signed [15:0]  sample,
   input  logic signed [15:0]  weight,
   input  logic                bias_add,
   input  logic signed [31:0]  bias,
   output logic signed [31:0]  sat_result
);
   import gc1d_pkg::*;

   logic signed [31:0]    prod_ff;
   logic                  pv_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (clear)         acc_in = '0;
      else if (pv_ff)    acc_in = acc_ff + ACC_W'(prod_ff);
      else if (bias_add) acc_in = acc_ff + ACC_W'(bias);
   end

   always_ff @(posedge clock) begin
      prod_ff <= sample * weight;
      pv_ff   <= valid;
      acc_ff  <= acc_in;
   end

   always_comb begin
      if (acc_ff > ACC_W'(64'sh7FFF_FFFF))       sat_result = 32'sh7FFF_FFFF;
      else if (acc_ff < -ACC_W'(64'sh8000_0000)) sat_result = 32'sh8000_0000;
      else                                      sat_result = acc_ff[31:0];
   end
endmodule

@@ rtl/gc1d_checker.sv @@
// Port-level checker for the convolution point engine, bound to the top level.
module gc1d_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);
   import gc1d_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_write_answers: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != FUNC_COMPUTE) |=>
         rsp_tvalid && (rsp_tuser == STAT_OK) && (rsp_tdata == '0))
      else $error("write transaction not answered next cycle");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_OK) |-> (rsp_tdata == '0) &&
         ((rsp_tuser == STAT_RANGE) || (rsp_tuser == STAT_CONFIG)))
      else $error("error result carries data or bad status");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");
endmodule

bind grouped_conv1d_point gc1d_checker u_gc1d_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/grouped_conv1d_point_test.sv @@
// Self-checking testbench for the grouped 1-D convolution point engine.
module grouped_conv1d_point_test;
   import gc1d_pkg::*;

   typedef struct {
      logic [31:0] point;
      status_type  status;
   } point_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   grouped_conv1d_point u_top (.*);

   always #10 clock = ~clock;

   // layer registers as the engine should see them
   int layer_in = 512, layer_out = 512, layer_taps = 3, layer_pad = 0;
   int layer_stride = 2, layer_groups = 1, layer_bias = 0, layer_frames = 256;

   // written store entries only
   logic signed [15:0] weight_mem[int];
   logic signed [31:0] bias_mem[int];
   logic signed [15:0] sample_mem[int];

   point_result_type pending_points[$];
   int error_count = 0;
   int item_count = 0;
   int send_idle_pct = 0, recv_idle_pct = 0, recv_hold = 0;

   function automatic status_type point_status(input int frame, input int chan);
      longint tout;
      if (layer_in == 0 || layer_in > MAX_CHANNELS || layer_out == 0 ||
          layer_out > MAX_CHANNELS || layer_groups == 0 || layer_groups > MAX_CHANNELS)
         return STAT_CONFIG;
      if (layer_in % layer_groups != 0 || layer_out % layer_groups != 0 ||
          layer_taps == 0 || layer_taps > MAX_TAPS || layer_stride == 0 ||
          layer_frames == 0 || layer_frames > MAX_FRAMES ||
          layer_frames + 2 * layer_pad < layer_taps)
         return STAT_CONFIG;
      if (longint'(layer_out) * layer_taps * (layer_in / layer_groups) > WEIGHT_WORDS)
         return STAT_CONFIG;
      tout = (layer_frames + 2 * layer_pad - layer_taps) / layer_stride + 1;
      if (frame >= tout || chan >= layer_out)
         return STAT_RANGE;
      return STAT_OK;
   endfunction

   function automatic point_result_type conv_point(input func_type func, input int frame,
      input int chan, input int waddr, input logic signed [15:0] sval,
      input logic signed [31:0] bval);
      point_result_type r;
      longint acc;
      int cin_g, grp, pos, si, wi;
      r.point = '0;
      r.status = STAT_OK;
      case (func)
         FUNC_WEIGHT: weight_mem[waddr] = sval;
         FUNC_BIAS:   bias_mem[chan] = bval;
         FUNC_SAMPLE: sample_mem[frame * MAX_CHANNELS + chan] = sval;
         default: begin
            r.status = point_status(frame, chan);
            if (r.status == STAT_OK) begin
               cin_g = layer_in / layer_groups;
               grp = chan / (layer_out / layer_groups);
               acc = 0;
               for (int kk = 0; kk < layer_taps; kk++) begin
                  pos = frame * layer_stride - layer_pad + kk;
                  if (pos < 0 || pos >= layer_frames) continue;
                  for (int c = 0; c < cin_g; c++) begin
                     si = pos * MAX_CHANNELS + grp * cin_g + c;
                     wi = chan * layer_taps * cin_g + kk * cin_g + c;
                     acc += longint'(sample_mem[si]) * longint'(weight_mem[wi]);
                  end
               end
               if (layer_bias) acc += longint'(bias_mem[chan]);
               if (acc > 64'sh7FFFFFFF) acc = 64'sh7FFFFFFF;
               if (acc < -64'sh80000000) acc = -64'sh80000000;
               r.point = acc[31:0];
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_item(input func_type func, input int frame, input int chan,
      input int waddr, input logic signed [15:0] sval, input logic signed [31:0] bval);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {2'b00, bval, sval, waddr[19:0], chan[9:0], frame[7:0]};
      do @(posedge clock); while (!req_tready);
      item_count++;
      pending_points.push_back(conv_point(func, frame & 'hFF, chan & 'h3FF,
                                          waddr & 'hFFFFF, sval, bval));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input reg_idx_type idx, input int value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_IN_CHANNELS:  layer_in = value & 'h7FF;
         REG_OUT_CHANNELS: layer_out = value & 'h7FF;
         REG_KERNEL_TAPS:  layer_taps = value & 'hFF;
         REG_PAD_FRAMES:   layer_pad = value & 'h7F;
         REG_STRIDE:       layer_stride = value & 'h1F;
         REG_GROUP_COUNT:  layer_groups = value & 'h7FF;
         REG_BIAS_ENABLE:  layer_bias = value & 1;
         default:          layer_frames = value & 'h1FF;
      endcase
   endtask

   task automatic set_layer(input int cin, input int cout, input int taps, input int pad,
      input int stride, input int groups, input int bias, input int frames);
      wait_drained();
      csr_write(REG_IN_CHANNELS, cin);
      csr_write(REG_OUT_CHANNELS, cout);
      csr_write(REG_KERNEL_TAPS, taps);
      csr_write(REG_PAD_FRAMES, pad);
      csr_write(REG_STRIDE, stride);
      csr_write(REG_GROUP_COUNT, groups);
      csr_write(REG_BIAS_ENABLE, bias);
      csr_write(REG_INPUT_FRAMES, frames);
   endtask

   // load every store entry the point reads that holds nothing yet, then compute it
   task automatic compute_loaded(input int frame, input int chan);
      int cin_g, grp, pos, si, wi;
      cin_g = layer_in / layer_groups;
      grp = chan / (layer_out / layer_groups);
      for (int kk = 0; kk < layer_taps; kk++) begin
         pos = frame * layer_stride - layer_pad + kk;
         if (pos < 0 || pos >= layer_frames) continue;
         for (int c = 0; c < cin_g; c++) begin
            si = pos * MAX_CHANNELS + grp * cin_g + c;
            wi = chan * layer_taps * cin_g + kk * cin_g + c;
            if (!sample_mem.exists(si))
               send_item(FUNC_SAMPLE, pos, grp * cin_g + c, $urandom_range(20'hFFFFF),
                         $urandom, $urandom);
            if (!weight_mem.exists(wi))
               send_item(FUNC_WEIGHT, $urandom_range(255), $urandom_range(1023), wi,
                         $urandom, $urandom);
         end
      end
      if (layer_bias && !bias_mem.exists(chan))
         send_item(FUNC_BIAS, $urandom_range(255), chan, $urandom_range(20'hFFFFF),
                   $urandom, $urandom);
      send_item(FUNC_COMPUTE, frame, chan, $urandom_range(20'hFFFFF), $urandom, $urandom);
   endtask

   // a random compute that lands in range goes through the loader
   task automatic send_noise(input func_type func);
      int frame, chan;
      frame = $urandom_range(255);
      chan = $urandom_range(1023);
      if (func == FUNC_COMPUTE && point_status(frame, chan) == STAT_OK)
         compute_loaded(frame, chan);
      else
         send_item(func, frame, chan, $urandom_range(20'hFFFFF), $urandom, $urandom);
   endtask

   task automatic test_writes_and_range();
      send_item(FUNC_WEIGHT, 0, 0, 0, -16'sd32768, 0);
      send_item(FUNC_WEIGHT, 255, 1023, 20'hFFFFF, 16'sd32767, -1);
      send_item(FUNC_BIAS, 0, 1023, 0, 0, 32'h80000000);
      send_item(FUNC_BIAS, 255, 0, 20'hFFFFF, -1, 32'h7FFFFFFF);
      send_item(FUNC_SAMPLE, 255, 1023, 0, 16'sh7FFF, 0);
      send_item(FUNC_SAMPLE, 0, 0, 20'hFFFFF, 16'sh8000, -1);
      send_item(FUNC_COMPUTE, 255, 0, 0, 0, 0);
      send_item(FUNC_COMPUTE, 0, 1023, 20'hFFFFF, -1, -1);
   endtask

   task automatic test_saturation();
      set_layer(4, 2, 1, 0, 1, 1, 1, 1);
      for (int c = 0; c < 4; c++) begin
         send_item(FUNC_SAMPLE, 0, c, 0, -16'sd32768, 0);
         send_item(FUNC_WEIGHT, 0, 0, c, -16'sd32768, 0);
         send_item(FUNC_WEIGHT, 0, 0, 4 + c, 16'sd32767, 0);
      end
      send_item(FUNC_BIAS, 0, 0, 0, 0, 32'h7FFFFFFF);
      send_item(FUNC_BIAS, 0, 1, 0, 0, 32'h80000000);
      send_item(FUNC_COMPUTE, 0, 0, 0, 0, 0);
      send_item(FUNC_COMPUTE, 0, 1, 0, 0, 0);
   endtask

   task automatic test_bad_layers();
      set_layer(0, 4, 1, 0, 1, 1, 0, 4);       send_noise(FUNC_COMPUTE);
      set_layer(2047, 4, 1, 0, 1, 1, 0, 4);    send_noise(FUNC_COMPUTE);
      set_layer(4, 6, 1, 0, 1, 4, 0, 4);       send_noise(FUNC_COMPUTE);
      set_layer(4, 4, 0, 0, 1, 1, 0, 4);       send_noise(FUNC_COMPUTE);
      set_layer(4, 4, 129, 127, 1, 1, 0, 4);   send_noise(FUNC_COMPUTE);
      set_layer(4, 4, 1, 0, 0, 1, 0, 4);       send_noise(FUNC_COMPUTE);
      set_layer(4, 4, 1, 0, 31, 0, 0, 0);      send_noise(FUNC_COMPUTE);
      set_layer(4, 4, 1, 0, 1, 1, 0, 511);     send_noise(FUNC_COMPUTE);
      set_layer(4, 4, 5, 1, 1, 1, 0, 2);       send_noise(FUNC_COMPUTE);
      set_layer(1024, 1024, 2, 0, 1, 1, 0, 4); send_noise(FUNC_COMPUTE);
   endtask

   task automatic test_widest_layer();
      // one channel per group, longest kernel, deepest padding, a stride of 16
      set_layer(1024, 1024, 128, 127, 16, 1024, 1, 1);
      for (int j = 0; j < 8; j++) compute_loaded(j, (j < 4) ? 1023 : j);
      send_item(FUNC_COMPUTE, 8, 0, 0, 0, 0);
      set_layer(1, 1, 1, 0, 1, 1, 0, 256);
      compute_loaded(255, 0);
   endtask

   task automatic test_random_layers(input int item_total);
      int sent, cin_g, cout_g, grp, taps, pad, frames, tout, pick;
      sent = item_count;
      while (item_count - sent < item_total) begin
         cin_g = $urandom_range(1, 4);
         cout_g = $urandom_range(1, 3);
         grp = $urandom_range(1, 3);
         taps = $urandom_range(1, 5);
         pad = $urandom_range(0, 3);
         frames = $urandom_range(1, 12);
         if (frames + 2 * pad < taps) frames = taps;
         if ($urandom_range(7) == 0)
            set_layer(cin_g * grp, cout_g * grp + 1, taps, pad, $urandom_range(1, 4), grp,
                      $urandom_range(1), frames);
         else
            set_layer(cin_g * grp, cout_g * grp, taps, pad, $urandom_range(1, 4), grp,
                      $urandom_range(1), frames);
         tout = (layer_frames + 2 * layer_pad - layer_taps) / layer_stride + 1;
         repeat ($urandom_range(15, 30)) begin
            if (item_count - sent >= item_total) break;
            pick = $urandom_range(99);
            if (pick < 55 && point_status(0, 0) == STAT_OK)
               compute_loaded($urandom_range(tout - 1), $urandom_range(layer_out - 1));
            else if (pick < 70)
               send_noise(FUNC_COMPUTE);
            else
               send_noise(func_type'($urandom_range(FUNC_SAMPLE)));
         end
      end
   endtask

   task automatic test_backpressure();
      set_layer(2, 2, 2, 1, 1, 1, 1, 4);
      recv_hold = 400;
      for (int j = 0; j < 6; j++) compute_loaded(j % 5, j % 2);
      wait_drained();
      for (int j = 0; j < 4; j++) compute_loaded(j, 1);
   endtask

   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      point_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected result transaction: conv_result %h status %0d",
                   rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_tdata !== want.point) begin
               $error("conv_result: expected %h, actual %h", want.point, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin
      #30_000_000;
      $display("grouped_conv1d_point regression: fail");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_writes_and_range();
      test_saturation();
      test_bad_layers();
      test_widest_layer();
      send_idle_pct = 29;
      recv_idle_pct = 60;
      test_random_layers(100);
      test_backpressure();
      send_idle_pct = 60;
      recv_idle_pct = 29;
      test_random_layers(100);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_layers(100);
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_points.size() == 0)
         $display("grouped_conv1d_point regression: pass");
      else
         $display("grouped_conv1d_point regression: fail");
      $finish;
   end

endmodule
